// ===== rtl/core/gcr_six_and_two_sector_decoder_top_macros.svh =====
// assertion macros shared by the decoder rtl
`ifndef GCR_SIX_AND_TWO_SECTOR_DECODER_TOP_MACROS_SVH
`define GCR_SIX_AND_TWO_SECTOR_DECODER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define GCR62_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("gcr62 invariant violated");
`define GCR62_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gcr62 sequence violated");
`else
`define GCR62_ASSERT(lbl, cond)
`define GCR62_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/gcr62_pkg.sv =====
package gcr62_pkg;

  localparam int NIB_W     = 8;
  localparam int SIX_W     = 6;
  localparam int POS_W     = 9;
  localparam int IDX_W     = 7;
  localparam int GRP_W     = 2;
  localparam int AUX_COUNT = 86;
  localparam int SUM_POS   = 342;

  // request to the auxiliary store: one address per cycle, write or read
  typedef struct packed {
    logic             we;
    logic             re;
    logic [IDX_W-1:0] addr;
    logic [SIX_W-1:0] wdata;
  } aux_req_t;

  typedef struct packed {
    logic             ok;
    logic [SIX_W-1:0] six;
  } lookup_t;

  // inverse of the 6-and-2 write translate table
  function automatic lookup_t untranslate(input logic [NIB_W-1:0] nib);
    lookup_t r;
    r.ok  = 1'b1;
    r.six = '0;
    case (nib)
      8'h96: r.six = 6'd0;
      8'h97: r.six = 6'd1;
      8'h9a: r.six = 6'd2;
      8'h9b: r.six = 6'd3;
      8'h9d: r.six = 6'd4;
      8'h9e: r.six = 6'd5;
      8'h9f: r.six = 6'd6;
      8'ha6: r.six = 6'd7;
      8'ha7: r.six = 6'd8;
      8'hab: r.six = 6'd9;
      8'hac: r.six = 6'd10;
      8'had: r.six = 6'd11;
      8'hae: r.six = 6'd12;
      8'haf: r.six = 6'd13;
      8'hb2: r.six = 6'd14;
      8'hb3: r.six = 6'd15;
      8'hb4: r.six = 6'd16;
      8'hb5: r.six = 6'd17;
      8'hb6: r.six = 6'd18;
      8'hb7: r.six = 6'd19;
      8'hb9: r.six = 6'd20;
      8'hba: r.six = 6'd21;
      8'hbb: r.six = 6'd22;
      8'hbc: r.six = 6'd23;
      8'hbd: r.six = 6'd24;
      8'hbe: r.six = 6'd25;
      8'hbf: r.six = 6'd26;
      8'hcb: r.six = 6'd27;
      8'hcd: r.six = 6'd28;
      8'hce: r.six = 6'd29;
      8'hcf: r.six = 6'd30;
      8'hd3: r.six = 6'd31;
      8'hd6: r.six = 6'd32;
      8'hd7: r.six = 6'd33;
      8'hd9: r.six = 6'd34;
      8'hda: r.six = 6'd35;
      8'hdb: r.six = 6'd36;
      8'hdc: r.six = 6'd37;
      8'hdd: r.six = 6'd38;
      8'hde: r.six = 6'd39;
      8'hdf: r.six = 6'd40;
      8'he5: r.six = 6'd41;
      8'he6: r.six = 6'd42;
      8'he7: r.six = 6'd43;
      8'he9: r.six = 6'd44;
      8'hea: r.six = 6'd45;
      8'heb: r.six = 6'd46;
      8'hec: r.six = 6'd47;
      8'hed: r.six = 6'd48;
      8'hee: r.six = 6'd49;
      8'hef: r.six = 6'd50;
      8'hf2: r.six = 6'd51;
      8'hf3: r.six = 6'd52;
      8'hf4: r.six = 6'd53;
      8'hf5: r.six = 6'd54;
      8'hf6: r.six = 6'd55;
      8'hf7: r.six = 6'd56;
      8'hf9: r.six = 6'd57;
      8'hfa: r.six = 6'd58;
      8'hfb: r.six = 6'd59;
      8'hfc: r.six = 6'd60;
      8'hfd: r.six = 6'd61;
      8'hfe: r.six = 6'd62;
      8'hff: r.six = 6'd63;
      default: begin
        r.ok  = 1'b0;
        r.six = '0;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/gcr62_aux_ram.sv =====
module gcr62_aux_ram (
  input  logic                             clk,
  input  gcr62_pkg::aux_req_t              req,
  output logic [gcr62_pkg::SIX_W-1:0]      rdata
);
  import gcr62_pkg::*;

  logic [SIX_W-1:0] mem [AUX_COUNT];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

// ===== rtl/core/gcr_six_and_two_sector_decoder_top.sv =====
// channel   | valid     | stall     | fields
// ----------+-----------+-----------+-------------------------------------------------
// input     | in_valid  | in_stall  | nibble
// output    | out_valid | out_stall | data_byte, is_status, sector_good, last_of_sector
//
// one nibble is taken per cycle while in_stall is low; a sector is 343 nibbles and gives 257 results
// a data byte passes from its nibble through stage 1, which holds the aux store read,
// and then through the result register
// no clearing pass after reset; the aux store is always written before it is read
// out_stall reaches in_stall only while both pipeline stages hold a request
`include "gcr_six_and_two_sector_decoder_top_macros.svh"

module gcr_six_and_two_sector_decoder_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gcr62_pkg::NIB_W-1:0]   nibble,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gcr62_pkg::NIB_W-1:0]   data_byte,
  output logic                          is_status,
  output logic                          sector_good,
  output logic                          last_of_sector
);
  import gcr62_pkg::*;

  localparam logic [POS_W-1:0] POS_AUX_END = POS_W'(AUX_COUNT);
  localparam logic [POS_W-1:0] POS_SUM     = POS_W'(SUM_POS);
  localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(AUX_COUNT - 1);

  // sector state
  logic [SIX_W-1:0] running_sum;
  logic [POS_W-1:0] position;
  logic [IDX_W-1:0] aux_index;
  logic [GRP_W-1:0] group_number;
  logic             error_seen;

  // stage 1: request with aux read pending
  logic             s1_valid;
  logic             s1_status;
  logic             s1_good;
  logic [SIX_W-1:0] s1_sum;
  logic [GRP_W-1:0] s1_grp;

  logic             in_accept;
  logic             out_load;
  logic             s1_load;
  lookup_t          lk;
  logic [SIX_W-1:0] sum_next;
  logic             at_sum;
  logic             in_aux;
  logic             idx_wrap;
  aux_req_t         aux_req;
  logic [SIX_W-1:0] aux_rdata;
  logic [1:0]       aux_pair;

  // output register frees when empty or taken; stage 1 moves whenever output can load
  assign out_load  = !out_valid || !out_stall;
  assign s1_load   = !s1_valid || out_load;
  assign in_stall  = !s1_load;
  assign in_accept = in_valid && s1_load;

  // table lookup and checksum chain
  assign lk       = untranslate(nibble);
  assign sum_next = running_sum ^ lk.six;
  assign at_sum   = (position == POS_SUM);
  assign in_aux   = (position < POS_AUX_END);
  assign idx_wrap = (aux_index == IDX_LAST);

  // aux nibbles write their chained value, data nibbles read the group back
  always_comb begin
    aux_req.we    = in_accept && !at_sum && in_aux;
    aux_req.re    = in_accept && !at_sum && !in_aux;
    aux_req.addr  = aux_index;
    aux_req.wdata = sum_next;
  end

  gcr62_aux_ram u_aux_ram (
    .clk   (clk),
    .req   (aux_req),
    .rdata (aux_rdata)
  );

  // sector bookkeeping, advanced once per accepted nibble
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      position     <= '0;
      aux_index    <= '0;
      group_number <= '0;
      error_seen   <= 1'b0;
    end else if (in_accept) begin
      if (at_sum) begin
        // checksum nibble closes the sector
        running_sum  <= '0;
        position     <= '0;
        aux_index    <= '0;
        group_number <= '0;
        error_seen   <= 1'b0;
      end else begin
        running_sum <= sum_next;
        position    <= position + POS_W'(1);
        error_seen  <= error_seen || !lk.ok;
        aux_index   <= idx_wrap ? '0 : aux_index + IDX_W'(1);
        if (!in_aux && idx_wrap) begin
          // next pass over the aux store uses the next bit pair
          group_number <= group_number + GRP_W'(1);
        end
      end
    end
  end

  // stage 1 register: control under reset, payload without reset, loaded on each accepted nibble
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= in_accept && (at_sum || !in_aux);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_status <= at_sum;
      s1_good   <= lk.ok && !error_seen && (lk.six == running_sum);
      s1_sum    <= sum_next;
      s1_grp    <= group_number;
    end
  end

  // select the bit pair for this pass
  always_comb begin
    case (s1_grp)
      2'd0:    aux_pair = aux_rdata[1:0];
      2'd1:    aux_pair = aux_rdata[3:2];
      default: aux_pair = aux_rdata[5:4];
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      if (s1_status) begin
        data_byte      <= '0;
        is_status      <= 1'b1;
        sector_good    <= s1_good;
        last_of_sector <= 1'b1;
      end else begin
        // stored low bits are kept pair swapped
        data_byte      <= {s1_sum, aux_pair[0], aux_pair[1]};
        is_status      <= 1'b0;
        sector_good    <= 1'b0;
        last_of_sector <= 1'b0;
      end
    end
  end

  // input only waits when both stages are full and the output is held
  `GCR62_ASSERT(a_stall_cause, !in_stall || (s1_valid && out_valid && out_stall))
  // position never runs past the checksum nibble
  `GCR62_ASSERT(a_pos_range, (position <= POS_SUM) && (group_number != 2'd3))
  // checksum nibble returns the sector state to zero
  `GCR62_ASSERT_NEXT(a_sector_restart, in_accept && at_sum,
                     (position == '0) && (running_sum == '0) && !error_seen)

endmodule
